// ===== hdl/sha512_pkg.sv =====
// Package with SHA-512 constants, types and round functions.
package sha512_pkg;

    localparam int unsigned Rounds = 80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    function automatic logic [63:0] f_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] f_iv(input logic [2:0] i);
        logic [63:0] v;
        case (i)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            default: v = 64'h5be0cd19137e2179;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] f_rotr(input logic [63:0] x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

// ===== hdl/sha512_round.sv =====
// Compression core: message schedule window and 80 rounds, one per cycle.
module sha512_round (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_rd_data,
    input  logic [511:0]  i_chain,
    output logic [3:0]    o_rd_addr,
    output logic [511:0]  o_chain,
    output logic          o_done
);
    import sha512_pkg::*;

    logic [63:0] r_w [16];
    logic [63:0] r_v [8];
    logic [63:0] r_h [8];
    logic [63:0] r_wx;
    logic [6:0]  r_t;
    logic        r_busy;
    logic        r_done;

    logic [63:0] s0, s1, wt, t1, t2, ch, mj, e, a;

    always_comb begin
        s0 = f_rotr(r_w[2], 1) ^ f_rotr(r_w[2], 8) ^ (r_w[2] >> 7);
        s1 = f_rotr(r_w[15], 19) ^ f_rotr(r_w[15], 61) ^ (r_w[15] >> 6);
        wt = (r_t < 7'd16) ? i_rd_data : r_wx;
        e  = r_v[4];
        a  = r_v[0];
        ch = (e & r_v[5]) ^ (~e & r_v[6]);
        mj = (a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + (f_rotr(e, 14) ^ f_rotr(e, 18) ^ f_rotr(e, 41)) + ch + f_k(r_t)
           + wt;
        t2 = (f_rotr(a, 28) ^ f_rotr(a, 34) ^ f_rotr(a, 39)) + mj;
    end

    assign o_rd_addr = i_start ? 4'd0 : r_t[3:0] + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_t    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_t    <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= i_chain[511 - 64*i -: 64];
                    r_h[i] <= i_chain[511 - 64*i -: 64];
                end
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= wt;
                r_wx   <= s1 + r_w[10] + s0 + r_w[1];
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_t    <= r_t + 7'd1;
                if (r_t == 7'(Rounds - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) o_chain[511 - 64*i -: 64] = r_h[i] + r_v[i];
    end

    assign o_done = r_done;
endmodule

// ===== hdl/sha512_hash_engine_core.sv =====
// Top level of the SHA-512 engine: block buffer memory, padding and digest output.
// A word that completes a block holds input through load, start, 80 rounds, done and
// chain update; other words are taken without a stall. A final word adds padding
// and one or two compressions, then eight digest items follow, one per accepted cycle.
// Synchronous active-low reset restores the initial hash values; no clearing pass.
module sha512_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_final_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_end
);
    import sha512_pkg::*;

    t_state r_state, n_state;
    logic [63:0]  r_blk [16];
    logic [63:0]  r_rd_data;
    logic [511:0] r_chain;
    logic [3:0]   r_pos;
    logic [63:0]  r_bytes;
    logic         r_fin;
    logic         r_marker;
    logic         r_len;
    logic [2:0]   r_idx;
    logic         r_ovalid;
    logic         r_start;
    logic [3:0]   rd_addr;
    logic [511:0] new_chain;
    logic         comp_done;

    logic [3:0]  cnt;
    logic [63:0] keep, padw, wr_data;
    logic        wr_en, acc;
    logic [511:0] iv_flat;

    always_comb begin
        for (int i = 0; i < 8; i++) iv_flat[511 - 64*i -: 64] = f_iv(3'(i));
    end

    sha512_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_rd_data (r_rd_data),
        .i_chain   (r_chain),
        .o_rd_addr (rd_addr),
        .o_chain   (new_chain),
        .o_done    (comp_done)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign acc     = i_valid && o_ready;

    always_comb begin
        cnt = (i_valid_bytes > 4'd8 || !i_final_word) ? 4'd8 : i_valid_bytes;
        keep = (cnt == 4'd0) ? 64'h0 : ~64'h0 << (7'd64 - {cnt[3:0], 3'b000});
        padw = (i_message_word & keep) | (64'h80 << (6'd56 - {cnt[2:0], 3'b000}));
    end

    always_comb begin
        n_state = r_state;
        wr_en   = 1'b0;
        wr_data = i_message_word;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    wr_en = 1'b1;
                    wr_data = (cnt == 4'd8) ? i_message_word : padw;
                    if (r_pos == 4'd15) n_state = ST_LOAD;
                    else if (i_final_word) n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                wr_en = 1'b1;
                if (r_marker) wr_data = 64'h8000000000000000;
                else if (r_pos == 4'd14) wr_data = {61'd0, r_bytes[63:61]};
                else if (r_pos == 4'd15 && r_len) wr_data = {r_bytes[60:0], 3'b000};
                else wr_data = 64'h0;
                if (r_pos == 4'd15) n_state = ST_LOAD;
            end
            ST_LOAD:   n_state = ST_ROUND;
            ST_ROUND:  if (comp_done) n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (!r_fin) n_state = ST_IDLE;
                else if (r_len) n_state = ST_EMIT;
                else n_state = ST_PAD;
            end
            ST_EMIT:   if (i_ready && r_idx == 3'd7) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_blk[r_pos] <= wr_data;
        r_rd_data <= r_blk[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chain  <= iv_flat;
            r_pos    <= '0;
            r_bytes  <= '0;
            r_fin    <= 1'b0;
            r_marker <= 1'b0;
            r_len    <= 1'b0;
            r_idx    <= '0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= (r_state == ST_LOAD);
            if (wr_en) r_pos <= r_pos + 4'd1;
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_bytes  <= r_bytes + {60'd0, cnt};
                        r_fin    <= i_final_word;
                        r_marker <= i_final_word && cnt == 4'd8;
                    end
                end
                ST_PAD: begin
                    r_marker <= 1'b0;
                    if (!r_marker && r_pos == 4'd14) r_len <= 1'b1;
                end
                ST_UPDATE: begin
                    r_chain <= new_chain;
                    if (r_fin && r_len) begin
                        r_ovalid <= 1'b1;
                        r_idx    <= '0;
                    end
                end
                ST_EMIT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_ovalid <= 1'b0;
                            r_chain  <= iv_flat;
                            r_bytes  <= '0;
                            r_fin    <= 1'b0;
                            r_len    <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_digest_word  = r_chain[511 - 64*r_idx -: 64];
    assign o_digest_index = r_idx;
    assign o_digest_end   = (r_idx == 3'd7);
endmodule
